@@ sv/cbe_pkg.sv @@
// Shared constants and controller/datapath interface types for the easing table.
`default_nettype none
package cbe_pkg;

	localparam int STEP_W      = 6;
	localparam int TABLE_STEPS = 1 << STEP_W;
	localparam int IDX_W       = STEP_W + 1;
	localparam int DIV_NW      = 44;
	localparam int DIV_DW      = 27;

	localparam logic [1:0] H_LOAD = 2'd0;
	localparam logic [1:0] H_B    = 2'd1;
	localparam logic [1:0] H_C    = 2'd2;
	localparam logic [1:0] H_END  = 2'd3;

	localparam logic [1:0] WS_ZERO = 2'd0;
	localparam logic [1:0] WS_ONE  = 2'd1;
	localparam logic [1:0] WS_WALK = 2'd2;

	localparam logic [1:0] IDX_HOLD = 2'd0;
	localparam logic [1:0] IDX_CLR  = 2'd1;
	localparam logic [1:0] IDX_ONE  = 2'd2;
	localparam logic [1:0] IDX_INC  = 2'd3;

	localparam logic [1:0] REG_X1 = 2'd0;
	localparam logic [1:0] REG_Y1 = 2'd1;
	localparam logic [1:0] REG_X2 = 2'd2;
	localparam logic [1:0] REG_Y2 = 2'd3;

	typedef struct packed {
		logic       take;
		logic       coef;
		logic       h_en;
		logic [1:0] h_op;
		logic       samp_we;
		logic       tt_we;
		logic [1:0] tt_wsel;
		logic [1:0] idx_op;
		logic       seg_clr;
		logic       seg_inc;
		logic       rd_sel;
		logic       cap_a;
		logic       cap_b;
		logic       shift;
		logic       mul_w;
		logic       div_start;
		logic       mul_e;
		logic       load_out;
		logic       out_built;
	} cmd_t;

	typedef struct packed {
		logic samp_last;
		logic walk_last;
		logic adv;
		logic dx_zero;
		logic div_done;
		logic out_busy;
	} sts_t;

endpackage
`default_nettype wire

@@ sv/cbe_div.sv @@
// Restoring divider producing one quotient bit per cycle.
`default_nettype none
module cbe_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [cbe_pkg::DIV_NW-1:0] num,
	input  wire logic [cbe_pkg::DIV_DW-1:0] den,
	output logic                            done,
	output logic [cbe_pkg::DIV_NW-1:0]      quo
);
	localparam int NW    = cbe_pkg::DIV_NW;
	localparam int DW    = cbe_pkg::DIV_DW;
	localparam int CNT_W = $clog2(NW);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NW-1:0]    num_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;
	logic [DW:0]      rem_sh;
	logic [DW:0]      diff;
	logic             ge;

	assign rem_sh = {rem_q, num_q[NW-1]};
	assign diff   = rem_sh - {1'b0, den_q};
	assign ge     = !diff[DW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
			num_q <= {num_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = num_q;
endmodule
`default_nettype wire

@@ sv/cbe_dp.sv @@
// Datapath: registers, sample and table memories, curve arithmetic and output register.
`default_nettype none
module cbe_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cbe_pkg::cmd_t       cmd,
	output cbe_pkg::sts_t            sts,
	input  wire logic                cfg_valid,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [18:0]         cfg_data,
	input  wire logic [16:0]         time_q16,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed [19:0]       position_q16,
	output logic                     built
);
	localparam int N     = cbe_pkg::TABLE_STEPS;
	localparam int SW    = cbe_pkg::STEP_W;
	localparam int IW    = cbe_pkg::IDX_W;
	localparam int NW    = cbe_pkg::DIV_NW;
	localparam int DW    = cbe_pkg::DIV_DW;

	function automatic logic signed [19:0] sat20(input logic signed [47:0] v);
		logic signed [19:0] r;
		if (v > 48'sd524287)
			r = 20'sd524287;
		else if (v < -48'sd524288)
			r = -20'sd524288;
		else
			r = v[19:0];
		return r;
	endfunction

	function automatic logic signed [47:0] rnd_shift(input logic signed [47:0] v, input int sh);
		logic signed [47:0] half;
		logic signed [47:0] r;
		half = 48'sd1 <<< (sh - 1);
		if (v >= 0)
			r = (v + half) >>> sh;
		else
			r = -((-v + half) >>> sh);
		return r;
	endfunction

	logic signed [18:0] x1_q, y1_q, x2_q, y2_q;
	logic signed [18:0] px1, px2;
	logic signed [23:0] ax_q, bx_q, cx_q, ay_q, by_q, cy_q;
	logic signed [47:0] hx_q, hy_q, ii, hx_add, hy_add;
	logic [IW-1:0]      idx_q, seg_q, rd_addr;
	logic signed [19:0] xs_mem [N+1];
	logic signed [19:0] ys_mem [N+1];
	logic signed [19:0] tt_mem [N+1];
	logic signed [19:0] rd_x_q, rd_y_q;
	logic signed [19:0] xa_q, xb_q, ya_q, yb_q;
	logic signed [20:0] dx_d, dy_d, sy_d;
	logic signed [26:0] tn_d, dn_d;
	logic signed [47:0] prod_d, prod_q, abs_p;
	logic [20:0]        dx_abs;
	logic               neg_q;
	logic [NW-1:0]      div_num;
	logic [DW-1:0]      div_den;
	logic               div_done;
	logic [NW-1:0]      quo;
	logic signed [47:0] walk_v;
	logic signed [19:0] avg_v;
	logic [IW-1:0]      tt_waddr;
	logic signed [19:0] tt_wdata;
	logic [16:0]        t_q;
	logic [IW-1:0]      ka, kb;
	logic signed [19:0] ra_q, rb_q, ea_q;
	logic signed [20:0] de_d;
	logic signed [37:0] pe_d, pe_q;
	logic signed [47:0] eval_v;
	logic               out_v_q;
	logic signed [19:0] pos_q;
	logic               built_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= 19'sd32768;
			y1_q <= 19'sd32768;
			x2_q <= 19'sd32768;
			y2_q <= 19'sd32768;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				cbe_pkg::REG_X1: x1_q <= cfg_data;
				cbe_pkg::REG_Y1: y1_q <= cfg_data;
				cbe_pkg::REG_X2: x2_q <= cfg_data;
				cbe_pkg::REG_Y2: y2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign px1 = (x1_q < 0 || x1_q > 19'sd65536) ? 19'sd32768 : x1_q;
	assign px2 = (x2_q < 0 || x2_q > 19'sd65536) ? 19'sd32768 : x2_q;

	always_ff @(posedge clk) begin
		if (cmd.coef) begin
			ax_q <= 24'sd3 * 24'(px1) - 24'sd3 * 24'(px2) + 24'sd65536;
			bx_q <= 24'sd3 * 24'(px2) - 24'sd6 * 24'(px1);
			cx_q <= 24'sd3 * 24'(px1);
			ay_q <= 24'sd3 * 24'(y1_q) - 24'sd3 * 24'(y2_q) + 24'sd65536;
			by_q <= 24'sd3 * 24'(y2_q) - 24'sd6 * 24'(y1_q);
			cy_q <= 24'sd3 * 24'(y1_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			seg_q <= '0;
		end else begin
			case (cmd.idx_op)
				cbe_pkg::IDX_CLR: idx_q <= '0;
				cbe_pkg::IDX_ONE: idx_q <= IW'(1);
				cbe_pkg::IDX_INC: idx_q <= idx_q + 1'b1;
				default: ;
			endcase
			if (cmd.seg_clr)
				seg_q <= '0;
			else if (cmd.seg_inc)
				seg_q <= seg_q + 1'b1;
		end
	end

	assign ii = 48'($signed({1'b0, idx_q}));

	always_comb begin
		case (cmd.h_op)
			cbe_pkg::H_B: begin
				hx_add = 48'(bx_q) <<< SW;
				hy_add = 48'(by_q) <<< SW;
			end
			cbe_pkg::H_C: begin
				hx_add = 48'(cx_q) <<< (2 * SW);
				hy_add = 48'(cy_q) <<< (2 * SW);
			end
			default: begin
				hx_add = '0;
				hy_add = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.h_en) begin
			if (cmd.h_op == cbe_pkg::H_LOAD) begin
				hx_q <= 48'(ax_q);
				hy_q <= 48'(ay_q);
			end else begin
				hx_q <= hx_q * ii + hx_add;
				hy_q <= hy_q * ii + hy_add;
			end
		end
	end

	assign rd_addr = cmd.rd_sel ? seg_q + 1'b1 : seg_q;

	always_ff @(posedge clk) begin
		if (cmd.samp_we) begin
			xs_mem[idx_q] <= sat20(rnd_shift(hx_q, 3 * SW));
			ys_mem[idx_q] <= sat20(rnd_shift(hy_q, 3 * SW));
		end
		rd_x_q <= xs_mem[rd_addr];
		rd_y_q <= ys_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_a) begin
			xa_q <= rd_x_q;
			ya_q <= rd_y_q;
		end else if (cmd.shift) begin
			xa_q <= xb_q;
			ya_q <= yb_q;
		end
		if (cmd.cap_b) begin
			xb_q <= rd_x_q;
			yb_q <= rd_y_q;
		end
	end

	assign tn_d   = $signed({4'b0, idx_q, 16'b0});
	assign dx_d   = 21'(xb_q) - 21'(xa_q);
	assign dy_d   = 21'(yb_q) - 21'(ya_q);
	assign sy_d   = 21'(yb_q) + 21'(ya_q);
	assign dn_d   = tn_d - (27'(xa_q) <<< SW);
	assign prod_d = dy_d * dn_d;
	assign dx_abs = dx_d[20] ? 21'(-dx_d) : 21'(dx_d);

	always_ff @(posedge clk) begin
		if (cmd.mul_w) begin
			prod_q <= prod_d;
			neg_q  <= prod_d[47] ^ dx_d[20];
		end
	end

	assign abs_p   = prod_q[47] ? -prod_q : prod_q;
	assign div_num = abs_p[NW-1:0] + NW'({dx_abs, 5'b0});
	assign div_den = DW'({dx_abs, 6'b0});

	cbe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (quo)
	);

	assign walk_v = neg_q ? 48'(ya_q) - 48'(quo) : 48'(ya_q) + 48'(quo);
	assign avg_v  = sat20(rnd_shift(48'(sy_d), 1));

	always_comb begin
		case (cmd.tt_wsel)
			cbe_pkg::WS_ZERO: begin
				tt_waddr = '0;
				tt_wdata = '0;
			end
			cbe_pkg::WS_ONE: begin
				tt_waddr = IW'(N);
				tt_wdata = 20'sd65536;
			end
			default: begin
				tt_waddr = idx_q;
				tt_wdata = (dx_d == 0) ? avg_v : sat20(walk_v);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.take)
			t_q <= time_q16;
	end

	assign ka = {1'b0, t_q[15:16-SW]};
	assign kb = ka + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.tt_we)
			tt_mem[tt_waddr] <= tt_wdata;
		ra_q <= tt_mem[ka];
		rb_q <= tt_mem[kb];
	end

	assign de_d = 21'(rb_q) - 21'(ra_q);
	assign pe_d = de_d * $signed({1'b0, t_q[15-SW:0], SW'(0)});

	always_ff @(posedge clk) begin
		if (cmd.mul_e) begin
			pe_q <= pe_d;
			ea_q <= ra_q;
		end
	end

	assign eval_v = 48'(ea_q) + rnd_shift(48'(pe_q), 16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (cmd.load_out)
			out_v_q <= 1'b1;
		else if (out_ready)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			built_q <= cmd.out_built;
			if (cmd.out_built)
				pos_q <= '0;
			else if (t_q[16])
				pos_q <= 20'sd65536;
			else
				pos_q <= sat20(eval_v);
		end
	end

	assign out_valid    = out_v_q;
	assign position_q16 = pos_q;
	assign built        = built_q;

	assign sts.samp_last = (idx_q == IW'(N));
	assign sts.walk_last = (idx_q == IW'(N - 1));
	assign sts.adv       = (seg_q < IW'(N - 1)) && (tn_d > (27'(xb_q) <<< SW));
	assign sts.dx_zero   = (dx_d == 0);
	assign sts.div_done  = div_done;
	assign sts.out_busy  = out_v_q & ~out_ready;
endmodule
`default_nettype wire

@@ sv/cbe_ctrl.sv @@
// Controller state machine sequencing table builds and evaluations.
`default_nettype none
module cbe_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic          op,
	input  wire cbe_pkg::sts_t sts,
	output cbe_pkg::cmd_t      cmd
);
	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_COEF  = 5'd1;
	localparam logic [4:0] S_HA    = 5'd2;
	localparam logic [4:0] S_HB    = 5'd3;
	localparam logic [4:0] S_HC    = 5'd4;
	localparam logic [4:0] S_HD    = 5'd5;
	localparam logic [4:0] S_HW    = 5'd6;
	localparam logic [4:0] S_T0    = 5'd7;
	localparam logic [4:0] S_TN    = 5'd8;
	localparam logic [4:0] S_WA    = 5'd9;
	localparam logic [4:0] S_WB    = 5'd10;
	localparam logic [4:0] S_WC    = 5'd11;
	localparam logic [4:0] S_WCHK  = 5'd12;
	localparam logic [4:0] S_WNB   = 5'd13;
	localparam logic [4:0] S_WMUL  = 5'd14;
	localparam logic [4:0] S_WDIV0 = 5'd15;
	localparam logic [4:0] S_WDIV  = 5'd16;
	localparam logic [4:0] S_WWR   = 5'd17;
	localparam logic [4:0] S_BDONE = 5'd18;
	localparam logic [4:0] S_ERD   = 5'd19;
	localparam logic [4:0] S_EMUL  = 5'd20;
	localparam logic [4:0] S_EFIN  = 5'd21;

	logic [4:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = op ? S_ERD : S_COEF;
				end
			end
			S_COEF: begin
				cmd.coef   = 1'b1;
				cmd.idx_op = cbe_pkg::IDX_CLR;
				state_d    = S_HA;
			end
			S_HA: begin
				cmd.h_en = 1'b1;
				cmd.h_op = cbe_pkg::H_LOAD;
				state_d  = S_HB;
			end
			S_HB: begin
				cmd.h_en = 1'b1;
				cmd.h_op = cbe_pkg::H_B;
				state_d  = S_HC;
			end
			S_HC: begin
				cmd.h_en = 1'b1;
				cmd.h_op = cbe_pkg::H_C;
				state_d  = S_HD;
			end
			S_HD: begin
				cmd.h_en = 1'b1;
				cmd.h_op = cbe_pkg::H_END;
				state_d  = S_HW;
			end
			S_HW: begin
				cmd.samp_we = 1'b1;
				if (sts.samp_last) begin
					state_d = S_T0;
				end else begin
					cmd.idx_op = cbe_pkg::IDX_INC;
					state_d    = S_HA;
				end
			end
			S_T0: begin
				cmd.tt_we   = 1'b1;
				cmd.tt_wsel = cbe_pkg::WS_ZERO;
				cmd.seg_clr = 1'b1;
				cmd.idx_op  = cbe_pkg::IDX_ONE;
				state_d     = S_TN;
			end
			S_TN: begin
				cmd.tt_we   = 1'b1;
				cmd.tt_wsel = cbe_pkg::WS_ONE;
				state_d     = S_WA;
			end
			S_WA: begin
				cmd.rd_sel = 1'b0;
				state_d    = S_WB;
			end
			S_WB: begin
				cmd.rd_sel = 1'b1;
				cmd.cap_a  = 1'b1;
				state_d    = S_WC;
			end
			S_WC: begin
				cmd.cap_b = 1'b1;
				state_d   = S_WCHK;
			end
			S_WCHK: begin
				if (sts.adv) begin
					cmd.seg_inc = 1'b1;
					cmd.shift   = 1'b1;
					state_d     = S_WNB;
				end else begin
					state_d = S_WMUL;
				end
			end
			S_WNB: begin
				cmd.rd_sel = 1'b1;
				state_d    = S_WC;
			end
			S_WMUL: begin
				cmd.mul_w = 1'b1;
				state_d   = sts.dx_zero ? S_WWR : S_WDIV0;
			end
			S_WDIV0: begin
				cmd.div_start = 1'b1;
				state_d       = S_WDIV;
			end
			S_WDIV: begin
				if (sts.div_done)
					state_d = S_WWR;
			end
			S_WWR: begin
				cmd.tt_we   = 1'b1;
				cmd.tt_wsel = cbe_pkg::WS_WALK;
				if (sts.walk_last) begin
					state_d = S_BDONE;
				end else begin
					cmd.idx_op = cbe_pkg::IDX_INC;
					state_d    = S_WCHK;
				end
			end
			S_BDONE: begin
				if (!sts.out_busy) begin
					cmd.load_out  = 1'b1;
					cmd.out_built = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_ERD: begin
				state_d = S_EMUL;
			end
			S_EMUL: begin
				cmd.mul_e = 1'b1;
				state_d   = S_EFIN;
			end
			S_EFIN: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule
`default_nettype wire

@@ sv/cubic_bezier_easing_table.sv @@
// Top level of the cubic-bezier easing table.
//
//  Channel   Direction  Handshake                      Contents
//  s_axis    in         s_axis_tvalid/s_axis_tready    time_q16, op in tuser
//  m_axis    out        m_axis_tvalid/m_axis_tready    position_q16, built in tuser
//  cfg       in         cfg_valid/cfg_ready            cfg_index, cfg_data
//
// An evaluate item passes through the table read, the interpolation multiply register and
// the rounding into the output register; evaluate items are taken one at a time, a new one
// only once the controller is idle again.
// A build item runs the Horner steps for each of the 65 curve samples, then walks the table
// entries, with segment advances as needed, dominated by the bit-serial divider that
// produces a 44-bit quotient.
// The result sits in an output register, so a new item is accepted while it waits.
// Reset is asynchronous and clears control state; the tables hold nothing valid until a build.
`default_nettype none
module cubic_bezier_easing_table (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // [16:0] time_q16
	input  wire logic        s_axis_tuser,  // [0] op
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // [19:0] position_q16
	output logic             m_axis_tuser,  // [0] built
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [18:0] cfg_data
);
	cbe_pkg::cmd_t      cmd;
	cbe_pkg::sts_t      sts;
	logic signed [19:0] position_q16;

	assign cfg_ready = 1'b1;

	cbe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.op       (s_axis_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	cbe_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.time_q16     (s_axis_tdata[16:0]),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.position_q16 (position_q16),
		.built        (m_axis_tuser)
	);

	assign m_axis_tdata = {4'b0, position_q16};
endmodule
`default_nettype wire
